>>> hdl/assert_macros.svh
// Assertion helpers used by slip_frame_decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and codes for the SLIP frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	typedef enum logic [1:0] {
		MODE_HUNT  = 2'd0,
		MODE_FRAME = 2'd1,
		MODE_ESC   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_block;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  data_out;
		logic [15:0] frame_length;
	} result_item_t;

endpackage

>>> hdl/slip_frame_decoder.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Receive side of a SLIP framer: strips END framing, undoes ESC sequences,
// reports frame completion with length or frame abort.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  byte      in         byte_valid / byte_ready       byte_item   (sfd_pkg::byte_item_t)
//  result    out        result_valid / result_ready   result_item (sfd_pkg::result_item_t)
//
// One byte per cycle sustained while the output register is free or drains.
// A byte is registered, decoded against the mode and count registers, and its
// result (if any) lands in the output register, which drives result_valid.
// A held result stalls the input stage only; byte_ready stays high while
// the input stage is empty or can drain. Reset returns to hunting, count 0.
`include "assert_macros.svh"

module slip_frame_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  sfd_pkg::byte_item_t   byte_item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output sfd_pkg::result_item_t result_item
);

	logic                  valid_s1;
	sfd_pkg::byte_item_t   item_s1;
	logic                  go_s1;

	sfd_pkg::mode_t        mode_q, mode_d;
	logic [15:0]           count_q, count_d;
	logic [15:0]           count_inc;

	logic                  res_fire;
	sfd_pkg::result_item_t res;

	logic                  out_valid_q;
	sfd_pkg::result_item_t out_item_q;

	assign go_s1      = valid_s1 && (!out_valid_q || result_ready);
	assign byte_ready = !valid_s1 || go_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	// mode and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sfd_pkg::MODE_HUNT;
			count_q <= 16'd0;
		end else if (go_s1) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	// saturating increment
	assign count_inc = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;

	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		res_fire = 1'b0;
		res      = '0;
		case (mode_q)
			sfd_pkg::MODE_FRAME: begin
				if (item_s1.rx_byte == sfd_pkg::SLIP_END) begin
					// empty frame END is ignored
					if (count_q != 16'd0) begin
						res_fire         = 1'b1;
						res.result_kind  = sfd_pkg::KIND_DONE;
						res.frame_length = count_q;
						mode_d           = sfd_pkg::MODE_HUNT;
						count_d          = 16'd0;
					end
				end else if (item_s1.rx_byte == sfd_pkg::SLIP_ESC) begin
					mode_d = sfd_pkg::MODE_ESC;
				end else begin
					res_fire        = 1'b1;
					res.result_kind = sfd_pkg::KIND_DATA;
					res.data_out    = item_s1.rx_byte;
					count_d         = count_inc;
				end
			end
			sfd_pkg::MODE_ESC: begin
				if (item_s1.rx_byte == sfd_pkg::SLIP_ESC_END ||
				    item_s1.rx_byte == sfd_pkg::SLIP_ESC_ESC) begin
					res_fire        = 1'b1;
					res.result_kind = sfd_pkg::KIND_DATA;
					res.data_out    = (item_s1.rx_byte == sfd_pkg::SLIP_ESC_END) ?
					                  sfd_pkg::SLIP_END : sfd_pkg::SLIP_ESC;
					count_d         = count_inc;
					mode_d          = sfd_pkg::MODE_FRAME;
				end else begin
					res_fire        = 1'b1;
					res.result_kind = sfd_pkg::KIND_ABORT;
					mode_d          = sfd_pkg::MODE_HUNT;
					count_d         = 16'd0;
				end
			end
			default: begin
				if (item_s1.rx_byte == sfd_pkg::SLIP_END) begin
					mode_d  = sfd_pkg::MODE_FRAME;
					count_d = 16'd0;
				end else begin
					mode_d = sfd_pkg::MODE_HUNT;
				end
			end
		endcase

		// end of block drops an unfinished frame
		if (item_s1.end_of_block &&
		    (mode_d == sfd_pkg::MODE_FRAME || mode_d == sfd_pkg::MODE_ESC)) begin
			res_fire        = 1'b1;
			res             = '0;
			res.result_kind = sfd_pkg::KIND_ABORT;
			mode_d          = sfd_pkg::MODE_HUNT;
			count_d         = 16'd0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_fire) begin
			out_item_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_item_q;

	`ASSERT_IMPLIES(a_hunt_count_zero, clk, arst_n,
		mode_q == sfd_pkg::MODE_HUNT, count_q == 16'd0)
	`ASSERT_IMPLIES(a_kind_legal, clk, arst_n,
		out_valid_q, out_item_q.result_kind != 2'd3)
	`ASSERT_NEXT(a_done_fields, clk, arst_n,
		go_s1 && res_fire && res.result_kind == sfd_pkg::KIND_DONE,
		out_item_q.frame_length != 16'd0 && out_item_q.data_out == 8'd0)

endmodule
